// File: rtl/core/tpbdt_pkg.sv
package tpbdt_pkg;

    // One color, 8 bits per channel.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_BLEND     = 3'd1,
        OP_MARK_ALL  = 3'd2,
        OP_AGE       = 3'd3,
        OP_READ_PIX  = 3'd4,
        OP_READ_MARK = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT  = 2'd0,
        REG_CANVAS_WIDTH  = 2'd1,
        REG_CANVAS_HEIGHT = 2'd2,
        REG_TILE_MARKING  = 2'd3
    } reg_index_t;

    localparam logic [1:0] MARK_IDLE    = 2'd0;
    localparam logic [1:0] MARK_TOUCHED = 2'd1;
    localparam logic [1:0] MARK_PREV    = 2'd2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;
    localparam int CFG_AW    = 4;

endpackage

// File: rtl/core/tiled_pixel_blend_dirty_tiles.sv
// Tiled framebuffer with alpha blending and per-tile update marks.
// s_* channel: one command item per handshake; s_tuser carries the opcode
// (opaque write, blend, mark all, age marks, read pixel, read mark).
// m_* channel: exactly one result item per command: the pixel and the tile
// mark at the addressed position after the command, plus a written flag.
// apb port: four 32-bit config registers at 0x0, 0x4, 0x8, 0xC.
// Each item steps through S_QUOT, S_CORR, S_INDEX and S_EXEC to S_DONE; a
// partial blend adds S_BLEND, and mark-all and age (marking on) add S_WALK,
// which visits one tile mark per cycle over all TILES_X*TILES_Y marks. One
// item is in flight at a time: a new one is taken only back in S_IDLE. The
// steps are the address path (reciprocal multiply, remainder fix-up, tile-major
// index) and the registered read of the pixel RAM ahead of the read-modify-write.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the finished item waits in the done state.
// Reset clears control, sets config to defaults and all tile marks to touched;
// the pixel RAM is not cleared and a pixel is defined only once written.
module tiled_pixel_blend_dirty_tiles
    import tpbdt_pkg::*;
#(
    parameter int TILE_SIDE  = 64,
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: pos_x[12:0], pos_y[25:13], red[33:26], green[41:34],
    //          blue[49:42], alpha[57:50], zero[63:58]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode[2:0]
    input  logic [2:0]            s_tuser,
    // m_tdata: pixel_value[23:0], tile_mark[25:24], zero[31:26]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: written[0]
    output logic                  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_AW-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // geometry
    localparam int TILES_X   = (MAX_WIDTH + TILE_SIDE - 1) / TILE_SIDE;
    localparam int TILES_Y   = (MAX_HEIGHT + TILE_SIDE - 1) / TILE_SIDE;
    localparam int NTILES    = TILES_X * TILES_Y;
    localparam int TILE_AREA = TILE_SIDE * TILE_SIDE;
    localparam int DEPTH     = NTILES * TILE_AREA;
    localparam int AW        = $clog2(DEPTH);
    localparam int TW        = (NTILES > 1) ? $clog2(NTILES) : 1;
    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int RW        = $clog2(TILE_SIDE);
    localparam int XYW       = (XW > YW) ? XW : YW;
    localparam int CW        = (XYW > RW + 2) ? XYW : RW + 2;
    localparam int SPAN_X    = TILES_X * TILE_SIDE;
    localparam int SPAN_Y    = TILES_Y * TILE_SIDE;
    localparam int GA        = ($clog2(SPAN_X + 1) > $clog2(SPAN_Y + 1)) ?
                               $clog2(SPAN_X + 1) : $clog2(SPAN_Y + 1);
    localparam int GW        = (GA > 12) ? GA : 12;
    // floor(2^24 / TILE_SIDE): quotient estimate is exact or one low
    localparam int RECIP_SH  = 24;
    localparam int RECIP     = (1 << RECIP_SH) / TILE_SIDE;
    localparam int PW        = CW + RECIP_SH + 1;

    typedef logic [AW-1:0] addr_t;
    typedef logic [TW-1:0] tidx_t;
    typedef logic [CW-1:0] crd_t;
    typedef logic [GW-1:0] gw_t;
    typedef logic [PW-1:0] prod_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QUOT,
        S_CORR,
        S_INDEX,
        S_EXEC,
        S_BLEND,
        S_WALK,
        S_DONE
    } state_t;

    // config registers
    logic       fmt_reg;
    logic [8:0] cw_reg;
    logic [8:0] ch_reg;
    logic       mark_en_reg;

    // item registers
    state_t      state_reg;
    logic [2:0]  op_reg;
    rgb_t        src_reg;
    logic [7:0]  alpha_reg;
    logic        on_reg;
    crd_t        ux_reg, uy_reg;
    crd_t        qx_reg, qy_reg;
    crd_t        rx_reg, ry_reg;
    tidx_t       tidx_reg;
    addr_t       pidx_reg;
    logic [23:0] val_reg;
    logic        written_reg;

    // walk counters
    tidx_t wi_reg;
    gw_t   wxp_reg, wyp_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // storage
    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;
    logic [1:0]  mark_reg [NTILES];

    // ---------------------------------------------------------------
    // input fields
    logic [12:0] in_x, in_y;
    rgb_t        in_src;
    logic [7:0]  in_alpha;
    gw_t         eff_w, eff_h;
    logic        in_on;

    assign in_x     = s_tdata[12:0];
    assign in_y     = s_tdata[25:13];
    assign in_src.r = s_tdata[33:26];
    assign in_src.g = s_tdata[41:34];
    assign in_src.b = s_tdata[49:42];
    assign in_alpha = s_tdata[57:50];

    // width/height saturate at the maximum canvas
    assign eff_w = (gw_t'(cw_reg) > gw_t'(MAX_WIDTH))  ? gw_t'(MAX_WIDTH)  : gw_t'(cw_reg);
    assign eff_h = (gw_t'(ch_reg) > gw_t'(MAX_HEIGHT)) ? gw_t'(MAX_HEIGHT) : gw_t'(ch_reg);

    assign in_on = !in_x[12] && !in_y[12] &&
                   (gw_t'(in_x[11:0]) < eff_w) && (gw_t'(in_y[11:0]) < eff_h);

    assign s_tready = (state_reg == S_IDLE);

    // ---------------------------------------------------------------
    // address path: quotient estimate, fix-up, tile-major index
    prod_t prod_x, prod_y;
    crd_t  qt_x, qt_y, rx_raw, ry_raw;
    logic  fix_x, fix_y;
    tidx_t tidx_calc;
    addr_t pidx_calc;

    assign prod_x = prod_t'(ux_reg) * prod_t'(RECIP);
    assign prod_y = prod_t'(uy_reg) * prod_t'(RECIP);

    assign qt_x   = crd_t'(qx_reg) * crd_t'(TILE_SIDE);
    assign qt_y   = crd_t'(qy_reg) * crd_t'(TILE_SIDE);
    assign rx_raw = ux_reg - qt_x;
    assign ry_raw = uy_reg - qt_y;
    assign fix_x  = (rx_raw >= crd_t'(TILE_SIDE));
    assign fix_y  = (ry_raw >= crd_t'(TILE_SIDE));

    assign tidx_calc = tidx_t'(qy_reg) * tidx_t'(TILES_X) + tidx_t'(qx_reg);
    assign pidx_calc = addr_t'(qy_reg) * addr_t'(TILES_X * TILE_AREA)
                     + addr_t'(qx_reg) * addr_t'(TILE_AREA)
                     + addr_t'(ry_reg) * addr_t'(TILE_SIDE)
                     + addr_t'(rx_reg);

    // ---------------------------------------------------------------
    // pixel format helpers
    function automatic logic [23:0] pack_rgb(input logic fmt, input rgb_t c);
        if (fmt) begin
            return {c.r, c.g, c.b};
        end
        return {8'h00, c.r[7:3], c.g[7:2], c.b[7:3]};
    endfunction

    function automatic rgb_t unpack_rgb(input logic fmt, input logic [23:0] v);
        rgb_t c;
        if (fmt) begin
            c = v;
        end else begin
            c.r = {v[15:11], 3'b000};
            c.g = {v[10:5], 2'b00};
            c.b = {v[4:0], 3'b000};
        end
        return c;
    endfunction

    function automatic logic [23:0] shown(input logic fmt, input logic [23:0] v);
        return fmt ? v : {8'h00, v[15:0]};
    endfunction

    // ---------------------------------------------------------------
    // blend unit: products taken in S_EXEC from the fresh RAM word
    rgb_t blend_res;

    tpbdt_blend u_blend (
        .aclk   (aclk),
        .mul_en (state_reg == S_EXEC),
        .dst    (unpack_rgb(fmt_reg, rdata_reg)),
        .src    (src_reg),
        .alpha  (alpha_reg),
        .result (blend_res)
    );

    // ---------------------------------------------------------------
    // command decode in S_EXEC
    logic is_full, is_blend, is_walk;

    assign is_full  = on_reg && ((op_reg == OP_WRITE) ||
                      ((op_reg == OP_BLEND) && (alpha_reg == 8'hFF)));
    assign is_blend = on_reg && (op_reg == OP_BLEND) &&
                      (alpha_reg != 8'h00) && (alpha_reg != 8'hFF);
    assign is_walk  = mark_en_reg && ((op_reg == OP_MARK_ALL) || (op_reg == OP_AGE));

    logic        mem_we;
    logic [23:0] mem_wdata;

    assign mem_we    = ((state_reg == S_EXEC) && is_full) || (state_reg == S_BLEND);
    assign mem_wdata = (state_reg == S_BLEND) ? pack_rgb(fmt_reg, blend_res)
                                              : pack_rgb(fmt_reg, src_reg);

    // ---------------------------------------------------------------
    // tile marks: single read port, walk index or addressed tile
    tidx_t      mrd_addr;
    logic [1:0] mrd;
    logic       in_use;
    logic       walk_last;
    logic [1:0] walk_mark;
    logic       mark_set;
    logic       walk_upd;
    logic       out_free;

    assign mrd_addr  = (state_reg == S_WALK) ? wi_reg : tidx_reg;
    assign mrd       = mark_reg[mrd_addr];
    assign in_use    = (wxp_reg < eff_w) && (wyp_reg < eff_h);
    assign walk_last = (wi_reg == tidx_t'(NTILES - 1));
    assign mark_set  = mark_en_reg && mem_we;
    assign walk_upd  = (state_reg == S_WALK) && in_use;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        walk_mark = mrd;
        if (op_reg == OP_MARK_ALL) begin
            walk_mark = MARK_TOUCHED;
        end else if (mrd == MARK_TOUCHED) begin
            walk_mark = MARK_PREV;
        end else if (mrd == MARK_PREV) begin
            walk_mark = MARK_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NTILES; k++) begin
                mark_reg[k] <= MARK_TOUCHED;
            end
        end else if (mark_set) begin
            mark_reg[tidx_reg] <= MARK_TOUCHED;
        end else if (walk_upd) begin
            mark_reg[wi_reg] <= walk_mark;
        end
    end

    // pixel RAM, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[pidx_reg] <= mem_wdata;
        end
        if (state_reg == S_INDEX) begin
            rdata_reg <= mem[pidx_calc];
        end
    end

    // ---------------------------------------------------------------
    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser;
                        src_reg   <= in_src;
                        alpha_reg <= in_alpha;
                        on_reg    <= in_on;
                        // off canvas folds to tile 0; results are masked
                        ux_reg    <= in_on ? crd_t'(in_x[XW-1:0]) : '0;
                        uy_reg    <= in_on ? crd_t'(in_y[YW-1:0]) : '0;
                        state_reg <= S_QUOT;
                    end
                end
                S_QUOT: begin
                    qx_reg    <= prod_x[RECIP_SH +: CW];
                    qy_reg    <= prod_y[RECIP_SH +: CW];
                    state_reg <= S_CORR;
                end
                S_CORR: begin
                    qx_reg    <= fix_x ? qx_reg + crd_t'(1) : qx_reg;
                    qy_reg    <= fix_y ? qy_reg + crd_t'(1) : qy_reg;
                    rx_reg    <= fix_x ? rx_raw - crd_t'(TILE_SIDE) : rx_raw;
                    ry_reg    <= fix_y ? ry_raw - crd_t'(TILE_SIDE) : ry_raw;
                    state_reg <= S_INDEX;
                end
                S_INDEX: begin
                    tidx_reg  <= tidx_calc;
                    pidx_reg  <= pidx_calc;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    written_reg <= is_full;
                    if (is_full) begin
                        val_reg   <= pack_rgb(fmt_reg, src_reg);
                        state_reg <= S_DONE;
                    end else if (is_blend) begin
                        state_reg <= S_BLEND;
                    end else begin
                        val_reg <= on_reg ? shown(fmt_reg, rdata_reg) : 24'h000000;
                        if (is_walk) begin
                            wi_reg    <= '0;
                            wxp_reg   <= '0;
                            wyp_reg   <= '0;
                            state_reg <= S_WALK;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_BLEND: begin
                    val_reg     <= pack_rgb(fmt_reg, blend_res);
                    written_reg <= 1'b1;
                    state_reg   <= S_DONE;
                end
                S_WALK: begin
                    wi_reg <= wi_reg + tidx_t'(1);
                    if (wxp_reg == gw_t'((TILES_X - 1) * TILE_SIDE)) begin
                        wxp_reg <= '0;
                        wyp_reg <= wyp_reg + gw_t'(TILE_SIDE);
                    end else begin
                        wxp_reg <= wxp_reg + gw_t'(TILE_SIDE);
                    end
                    if (walk_last) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b000000, on_reg ? mrd : MARK_IDLE, val_reg};
                        m_tuser_reg  <= written_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------
    // config port, writes land on the access cycle
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg     <= 1'b0;
            cw_reg      <= 9'd256;
            ch_reg      <= 9'd256;
            mark_en_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_PIXEL_FORMAT:  fmt_reg     <= pwdata[0];
                REG_CANVAS_WIDTH:  cw_reg      <= pwdata[8:0];
                REG_CANVAS_HEIGHT: ch_reg      <= pwdata[8:0];
                REG_TILE_MARKING:  mark_en_reg <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_PIXEL_FORMAT:  prdata = {31'd0, fmt_reg};
            REG_CANVAS_WIDTH:  prdata = {23'd0, cw_reg};
            REG_CANVAS_HEIGHT: prdata = {23'd0, ch_reg};
            REG_TILE_MARKING:  prdata = {31'd0, mark_en_reg};
        endcase
    end

endmodule

// File: rtl/core/tpbdt_blend.sv
// Per-channel blend (dst*(255-a) + src*a) / 255, truncated.
// Products are registered on mul_en; the divide by 255 follows combinationally.
module tpbdt_blend
    import tpbdt_pkg::*;
(
    input  logic       aclk,
    input  logic       mul_en,
    input  rgb_t       dst,
    input  rgb_t       src,
    input  logic [7:0] alpha,
    output rgb_t       result
);

    logic [7:0]  d_ch [3];
    logic [7:0]  s_ch [3];
    logic [7:0]  inv_a;
    logic [15:0] pd_reg [3];
    logic [15:0] ps_reg [3];
    logic [7:0]  q_ch [3];

    assign d_ch[0] = dst.r;
    assign d_ch[1] = dst.g;
    assign d_ch[2] = dst.b;
    assign s_ch[0] = src.r;
    assign s_ch[1] = src.g;
    assign s_ch[2] = src.b;
    assign inv_a   = 8'hFF - alpha;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            for (int c = 0; c < 3; c++) begin
                pd_reg[c] <= 16'(d_ch[c]) * 16'(inv_a);
                ps_reg[c] <= 16'(s_ch[c]) * 16'(alpha);
            end
        end
    end

    // x/255 == (x + (x >> 8) + 1) >> 8 for every x up to 255*255
    always_comb begin
        logic [16:0] sum;
        logic [16:0] adj;
        for (int c = 0; c < 3; c++) begin
            sum     = 17'(pd_reg[c]) + 17'(ps_reg[c]);
            adj     = sum + (sum >> 8) + 17'd1;
            q_ch[c] = adj[15:8];
        end
    end

    assign result.r = q_ch[0];
    assign result.g = q_ch[1];
    assign result.b = q_ch[2];

endmodule

// File: sim/tpbdt_checker.sv
`timescale 1ns / 1ps

module tpbdt_checker
    import tpbdt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [2:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CFG_AW-1:0]    paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending
);

    localparam int SIDE    = 64;
    localparam int CANVAS  = 256;
    localparam int TILES_X = CANVAS / SIDE;
    localparam int N_TILES = TILES_X * TILES_X;

    typedef struct packed {
        logic [23:0] pixel;
        logic [1:0]  mark;
        logic        written;
    } readback_t;

    // pixels kept row-major; any one-to-one layout gives the same results
    logic [23:0] canvas_px [CANVAS*CANVAS];
    logic [1:0]  tile_state [N_TILES];
    logic        fmt_888;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic        marking_on;
    readback_t   readback_q[$];

    function automatic logic [23:0] pack_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (fmt_888)
            return {r, g, b};
        return {8'h00, r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [7:0] mix(logic [7:0] d, logic [7:0] s, logic [7:0] a);
        int acc;
        acc = (int'(d) * (255 - int'(a)) + int'(s) * int'(a)) / 255;
        return acc[7:0];
    endfunction

    task automatic apply_command(input logic [2:0] op, input logic signed [12:0] px,
                                 input logic signed [12:0] py, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b,
                                 input logic [7:0] a, output readback_t res);
        int x, y, w, h, cols, rows, tidx, pidx;
        bit on;
        logic [23:0] dst;
        logic [7:0] dr, dg, db;
        x = px;
        y = py;
        w = (width_reg > CANVAS) ? CANVAS : width_reg;
        h = (height_reg > CANVAS) ? CANVAS : height_reg;
        on = x >= 0 && y >= 0 && x < w && y < h;
        tidx = on ? (y / SIDE) * TILES_X + x / SIDE : 0;
        pidx = on ? y * CANVAS + x : 0;
        res = '0;
        if (op == OP_WRITE || (op == OP_BLEND && a == 8'hFF)) begin
            if (on) begin
                canvas_px[pidx] = pack_color(r, g, b);
                res.written = 1'b1;
            end
        end else if (op == OP_BLEND) begin
            if (on && a != 8'h00) begin
                dst = canvas_px[pidx];
                if (fmt_888) begin
                    dr = dst[23:16];
                    dg = dst[15:8];
                    db = dst[7:0];
                end else begin
                    dr = {dst[15:11], 3'b000};
                    dg = {dst[10:5], 2'b00};
                    db = {dst[4:0], 3'b000};
                end
                canvas_px[pidx] = pack_color(mix(dr, r, a), mix(dg, g, a), mix(db, b, a));
                res.written = 1'b1;
            end
        end else if ((op == OP_MARK_ALL || op == OP_AGE) && marking_on) begin
            cols = (w + SIDE - 1) / SIDE;
            rows = (h + SIDE - 1) / SIDE;
            for (int j = 0; j < rows; j++)
                for (int i = 0; i < cols; i++) begin
                    if (op == OP_MARK_ALL)
                        tile_state[j*TILES_X+i] = MARK_TOUCHED;
                    else if (tile_state[j*TILES_X+i] == MARK_TOUCHED)
                        tile_state[j*TILES_X+i] = MARK_PREV;
                    else if (tile_state[j*TILES_X+i] == MARK_PREV)
                        tile_state[j*TILES_X+i] = MARK_IDLE;
                end
        end
        if (res.written && marking_on)
            tile_state[tidx] = MARK_TOUCHED;
        if (on) begin
            res.pixel = fmt_888 ? canvas_px[pidx] : {8'h00, canvas_px[pidx][15:0]};
            res.mark  = tile_state[tidx];
        end
    endtask

    always @(posedge aclk) begin
        readback_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < N_TILES; i++)
                tile_state[i] = MARK_TOUCHED;
            fmt_888    = 1'b0;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            marking_on = 1'b1;
            readback_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[3:2]))
                    REG_PIXEL_FORMAT:  fmt_888    = pwdata[0];
                    REG_CANVAS_WIDTH:  width_reg  = pwdata[8:0];
                    REG_CANVAS_HEIGHT: height_reg = pwdata[8:0];
                    REG_TILE_MARKING:  marking_on = pwdata[0];
                    default: ;
                endcase
            end
            // result first: an item accepted at this edge cannot have finished yet
            if (m_tvalid && m_tready) begin
                got.pixel   = m_tdata[23:0];
                got.mark    = m_tdata[25:24];
                got.written = m_tuser;
                if (readback_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, got %06h/%0d/%0b",
                             $time, got.pixel, got.mark, got.written);
                    fail_count <= fail_count + 1;
                end else begin
                    want = readback_q.pop_front();
                    if (got !== want) begin
                        // pixel/mark/written
                        $display("%0t mismatch: expected %06h/%0d/%0b, got %06h/%0d/%0b",
                                 $time, want.pixel, want.mark, want.written,
                                 got.pixel, got.mark, got.written);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_command(s_tuser, s_tdata[12:0], s_tdata[25:13], s_tdata[33:26],
                              s_tdata[41:34], s_tdata[49:42], s_tdata[57:50], want);
                readback_q.push_back(want);
            end
        end
        pending <= readback_q.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import tpbdt_pkg::*;

    // opcodes outside the decoded set; the block answers them like a read
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int CANVAS       = 256;
    // mark-all / age walk 16 marks after the address path; pad well past that
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    int fail_count;
    int pending;

    // per-cycle odds (percent) of a sender gap and of a receiver stall
    int send_idle_pct;
    int stall_pct;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int hold_req;

    // mirror of what was last written to the registers
    int cfg_888;
    int cfg_w;
    int cfg_h;
    int cfg_mark;

    // pixels written so far; only these may be read back on canvas
    bit pix_seen [CANVAS*CANVAS];
    int pix_list[$];

    tiled_pixel_blend_dirty_tiles DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tpbdt_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // hard stop in case a handshake never completes
    initial begin
        #(20 * 400000);
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request so the
    // block fills up and pushes back on the command side
    initial begin : rx_side
        int hold_cnt;
        int hold_seen;
        hold_cnt = 0;
        hold_seen = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                m_tready <= 1'b0;
                hold_cnt--;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_cnt = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic bit visible(int x, int y);
        int w, h;
        w = (cfg_w > CANVAS) ? CANVAS : cfg_w;
        h = (cfg_h > CANVAS) ? CANVAS : cfg_h;
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    // stop offering, wait for every outstanding result, then let the
    // mark walk settle; the first edge lets pending catch up with the
    // item accepted in this step
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int fmt, input int w, input int h, input int mark);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_CANVAS_WIDTH, w);
        write_reg(REG_CANVAS_HEIGHT, h);
        write_reg(REG_TILE_MARKING, mark);
        cfg_888  = fmt;
        cfg_w    = w;
        cfg_h    = h;
        cfg_mark = mark;
    endtask

    // offer one command item and hold it until accepted; valid stays high
    // on return so a back-to-back item can follow in the same step
    task automatic send_cmd(input logic [2:0] op, input int x, input int y,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
        int idx;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, a, b, g, r, y[12:0], x[12:0]};
        do @(posedge aclk); while (!s_tready);
        if ((op == OP_WRITE || (op == OP_BLEND && a == 8'hFF)) && visible(x, y)) begin
            idx = y * CANVAS + x;
            if (!pix_seen[idx]) begin
                pix_seen[idx] = 1'b1;
                pix_list.push_back(idx);
            end
        end
    endtask

    // positions off the canvas: just past the left, right or bottom edge, or anywhere in range
    task automatic off_pos(output int x, output int y);
        int w, h;
        w = (cfg_w > CANVAS) ? CANVAS : cfg_w;
        h = (cfg_h > CANVAS) ? CANVAS : cfg_h;
        do begin
            case ($urandom_range(0, 3))
                0: begin
                    x = -1 - int'($urandom_range(0, 3));
                    y = $urandom_range(0, CANVAS - 1);
                end
                1: begin
                    x = w + int'($urandom_range(0, 3));
                    y = $urandom_range(0, CANVAS - 1);
                end
                2: begin
                    x = $urandom_range(0, CANVAS - 1);
                    y = h + int'($urandom_range(0, 3));
                end
                default: begin
                    x = int'($urandom_range(0, 8191)) - 4096;
                    y = int'($urandom_range(0, 8191)) - 4096;
                end
            endcase
        end while (visible(x, y));
    endtask

    task automatic on_pos(output int x, output int y);
        int w, h;
        w = (cfg_w > CANVAS) ? CANVAS : cfg_w;
        h = (cfg_h > CANVAS) ? CANVAS : cfg_h;
        if (w == 0 || h == 0) begin
            off_pos(x, y);
        end else begin
            // corners and edges now and then
            x = ($urandom_range(0, 5) == 0) ? w - 1 : $urandom_range(0, w - 1);
            y = ($urandom_range(0, 5) == 0) ? h - 1 : $urandom_range(0, h - 1);
        end
    endtask

    // a pixel that was written, often the latest one (write, blend, read)
    task automatic known_pos(output int x, output int y);
        int k;
        if (pix_list.size() == 0) begin
            off_pos(x, y);
        end else begin
            k = ($urandom_range(0, 3) == 0) ? pix_list.size() - 1
                                            : $urandom_range(0, pix_list.size() - 1);
            x = pix_list[k] % CANVAS;
            y = pix_list[k] / CANVAS;
        end
    endtask

    task automatic random_cmd();
        int sel, x, y;
        logic [2:0] op;
        logic [7:0] a;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       a = 8'h00;
            1:       a = 8'hFF;
            default: a = 8'($urandom_range(0, 255));
        endcase
        if (sel < 30)      op = OP_WRITE;
        else if (sel < 55) op = OP_BLEND;
        else if (sel < 60) op = OP_MARK_ALL;
        else if (sel < 66) op = OP_AGE;
        else if (sel < 82) op = OP_READ_PIX;
        else if (sel < 96) op = OP_READ_MARK;
        else if (sel < 98) op = OP_SPARE_LO;
        else               op = OP_SPARE_HI;
        // anything that reports the pixel needs it written first, unless off canvas
        if (op == OP_WRITE || (op == OP_BLEND && a == 8'hFF)) begin
            if ($urandom_range(0, 9) == 0) off_pos(x, y);
            else on_pos(x, y);
        end else if ($urandom_range(0, 9) == 0) begin
            off_pos(x, y);
        end else begin
            known_pos(x, y);
        end
        send_cmd(op, x, y, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), a);
    endtask

    initial begin : stimulus
        int p, n;
        int widths [PHASES];
        int heights [PHASES];
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 0;
        cfg_888       = 0;
        cfg_w         = 256;
        cfg_h         = 256;
        cfg_mark      = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset setup, RGB565, full canvas, marking on
        send_cmd(OP_WRITE,       0,    0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_cmd(OP_WRITE,     255,  255, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(OP_READ_PIX,    0,    0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(OP_READ_MARK, 255,  255, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(OP_BLEND,       0,    0, 8'h00, 8'h00, 8'h00, 8'h80);
        // zero alpha: no change, no mark
        send_cmd(OP_BLEND,       0,    0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        // full alpha acts as an opaque write
        send_cmd(OP_BLEND,     255,  255, 8'h0C, 8'hC8, 8'h4D, 8'hFF);
        send_cmd(OP_AGE,         0,    0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(OP_AGE,       255,  255, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(OP_MARK_ALL,    0,    0, 8'h00, 8'h00, 8'h00, 8'h00);
        // off canvas on every side and at the field limits
        send_cmd(OP_WRITE,      -1,    0, 8'h12, 8'h34, 8'h56, 8'h00);
        send_cmd(OP_WRITE,     256,    3, 8'h12, 8'h34, 8'h56, 8'h00);
        send_cmd(OP_BLEND,   -4096,-4096, 8'hFF, 8'hFF, 8'hFF, 8'h40);
        send_cmd(OP_READ_PIX, 4095, 4095, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(OP_SPARE_LO,    0,    0, 8'hAA, 8'h55, 8'hAA, 8'hFF);
        send_cmd(OP_SPARE_HI,  255,  255, 8'h55, 8'hAA, 8'h55, 8'hFF);
        // pixel on a tile boundary
        send_cmd(OP_WRITE,      63,   64, 8'h81, 8'h42, 8'h24, 8'h00);
        send_cmd(OP_READ_MARK,  63,   64, 8'h00, 8'h00, 8'h00, 8'h00);

        // RGB888 on a 1x1 canvas with marking off
        configure(1, 1, 1, 0);
        send_cmd(OP_WRITE,       0,    0, 8'hC3, 8'h3C, 8'h99, 8'h00);
        send_cmd(OP_WRITE,       1,    0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_cmd(OP_BLEND,       0,    0, 8'h10, 8'hF0, 8'h01, 8'h4D);
        send_cmd(OP_MARK_ALL,    0,    0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(OP_AGE,         0,    0, 8'h00, 8'h00, 8'h00, 8'h00);
        // format switch: the RGB888 word read back as RGB565
        configure(0, 1, 1, 1);
        send_cmd(OP_READ_PIX,    0,    0, 8'h00, 8'h00, 8'h00, 8'h00);
        // empty canvas: nothing on it, nothing to mark
        configure(0, 0, 0, 1);
        send_cmd(OP_MARK_ALL,    0,    0, 8'h00, 8'h00, 8'h00, 8'h00);
        // oversized canvas saturates to the full store
        configure(1, 511, 300, 1);
        send_cmd(OP_WRITE,     255,  255, 8'h7F, 8'h80, 8'h01, 8'h00);
        send_cmd(OP_BLEND,     255,  255, 8'hFE, 8'h02, 8'hFF, 8'hC8);
        send_cmd(OP_AGE,       255,  255, 8'h00, 8'h00, 8'h00, 8'h00);

        // random phases; canvas extremes and both formats, idling mode per phase
        widths  = '{256, 1, $urandom_range(1, 256), 256, 64, 65, $urandom_range(1, 256), 256};
        heights = '{256, 256, 1, $urandom_range(1, 256), 256, 63, $urandom_range(1, 256), 256};
        for (p = 0; p < PHASES; p++) begin
            configure(p % 2, widths[p], heights[p], (p == 3 || p == 6) ? 0 : 1);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 51; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while commands keep coming
                if (p == 4 && n == 40)
                    hold_req++;
                // sender pause until the block has answered everything
                if (p == 6 && n == 50)
                    wait_idle();
                random_cmd();
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tpbdt_pkg.sv
rtl/core/tpbdt_blend.sv
rtl/core/tiled_pixel_blend_dirty_tiles.sv
sim/tpbdt_checker.sv
sim/tb.sv
